// ===== design/hrbt_pkg.sv =====
// Shared constants for the heap region bounds table.
package hrbt_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int FIELD_W            = 32;
   localparam int COUNT_OUT_W        = 9;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_CHECK  = 1'b1;

endpackage

// ===== design/heap_region_bounds_table_top.sv =====
// Top level of the heap region bounds table: sequencer, region RAM and shared comparator.
//
// The request channel carries a mode, an address and a length. A record request
// (mode 0) appends a region with that base and size; when the table already holds
// DEPTH regions the record is refused and the response shows dropped. A check
// request (mode 1) asks whether the access [addr, addr + length] lies inside any
// stored region. Every request yields exactly one response on the rsp channel
// carrying in_bounds, dropped and the number of stored regions after the request.
// For a record, and for a check on an empty table, the response is valid in the cycle
// after the request is taken. A check on a table of N regions reads the regions one
// per cycle from the region RAM through the single comparator and answers once the
// scan has passed through the drain and finish states.
// The block takes one request at a time and stalls the request side while a check
// scans. The response is held in an output register; while the receiver stalls it
// keeps its value, and a new request is taken only once that slot is free or
// being emptied in the same cycle. Reset empties the table and drops any pending
// response; no clearing pass is needed since only written entries are ever read.
module heap_region_bounds_table_top #(
   parameter int DEPTH      = hrbt_pkg::DEPTH_DEFAULT,
   parameter int ADDR_WIDTH = hrbt_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [hrbt_pkg::FIELD_W-1:0]      req_addr,
   input  logic [hrbt_pkg::FIELD_W-1:0]      req_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_in_bounds,
   output logic                              rsp_dropped,
   output logic [hrbt_pkg::COUNT_OUT_W-1:0]  rsp_used_entries
);

   import hrbt_pkg::*;

   localparam int DW    = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [DW-1:0]          acc_addr_ff, acc_addr_in;
   logic [DW:0]            acc_end_ff, acc_end_in;
   logic                   hit_acc_ff, hit_acc_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_in_bounds_ff, rsp_in_bounds_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;
   logic [COUNT_OUT_W-1:0] rsp_used_ff, rsp_used_in;

   logic                   req_fire;
   logic                   full;
   logic                   wr_en;
   logic [DW-1:0]          req_addr_trim;
   logic [DW-1:0]          req_length_trim;
   logic [CNT_W-1:0]       count_inc;
   logic [CNT_W-1:0]       count_dec;
   logic [CNT_W+COUNT_OUT_W-1:0] used_wide;
   logic [2*DW-1:0]        rd_data;
   logic                   fit_hit;

   assign req_stall       = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire        = req_valid && !req_stall;
   assign full            = (count_ff == CNT_W'(DEPTH));
   assign req_addr_trim   = req_addr[DW-1:0];
   assign req_length_trim = req_length[DW-1:0];
   assign count_inc       = count_ff + 1'b1;
   assign count_dec       = count_ff - 1'b1;
   assign wr_en           = req_fire && (req_mode == MODE_RECORD) && !full;
   assign used_wide       = {{COUNT_OUT_W{1'b0}}, (wr_en ? count_inc : count_ff)};

   hrbt_ram #(
      .WIDTH (2 * DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_length_trim, req_addr_trim}),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   hrbt_fit #(
      .DW (DW)
   ) u_fit (
      .clock    (clock),
      .reset    (reset),
      .valid    (rd_vld_ff),
      .base     (rd_data[DW-1:0]),
      .size     (rd_data[2*DW-1:DW]),
      .acc_addr (acc_addr_ff),
      .acc_end  (acc_end_ff),
      .hit      (fit_hit)
   );

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      acc_addr_in      = acc_addr_ff;
      acc_end_in       = acc_end_ff;
      hit_acc_in       = hit_acc_ff | fit_hit;
      rd_vld_in        = (state_ff == ST_SCAN);
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in_bounds_in = rsp_in_bounds_ff;
      rsp_dropped_in   = rsp_dropped_ff;
      rsp_used_in      = rsp_used_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_RECORD) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in_bounds_in = 1'b0;
                  rsp_dropped_in   = full;
                  rsp_used_in      = used_wide[COUNT_OUT_W-1:0];
                  if (!full) begin
                     count_in = count_inc;
                  end
               end else begin
                  acc_addr_in = req_addr_trim;
                  acc_end_in  = {1'b0, req_addr_trim} + {1'b0, req_length_trim};
                  hit_acc_in  = 1'b0;
                  if (count_ff == '0) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in_bounds_in = 1'b0;
                     rsp_dropped_in   = 1'b0;
                     rsp_used_in      = used_wide[COUNT_OUT_W-1:0];
                  end else begin
                     idx_in   = count_dec[IDX_W-1:0];
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in     = 1'b1;
            rsp_in_bounds_in = hit_acc_ff | fit_hit;
            rsp_dropped_in   = 1'b0;
            rsp_used_in      = used_wide[COUNT_OUT_W-1:0];
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_acc_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_acc_ff   <= hit_acc_in;
      end
      idx_ff           <= idx_in;
      acc_addr_ff      <= acc_addr_in;
      acc_end_ff       <= acc_end_in;
      rsp_in_bounds_ff <= rsp_in_bounds_in;
      rsp_dropped_ff   <= rsp_dropped_in;
      rsp_used_ff      <= rsp_used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_bounds    = rsp_in_bounds_ff;
   assign rsp_dropped      = rsp_dropped_ff;
   assign rsp_used_entries = rsp_used_ff;

endmodule

// ===== design/hrbt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module hrbt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hrbt_fit.sv =====
// Shared bounds comparator: tests one stored region against the access and registers the hit.
module hrbt_fit #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid,
   input  logic [DW-1:0] base,
   input  logic [DW-1:0] size,
   input  logic [DW-1:0] acc_addr,
   input  logic [DW:0]   acc_end,
   output logic          hit
);

   logic [DW:0] region_end;
   logic        fits;
   logic        hit_ff;
   logic        hit_in;

   assign region_end = {1'b0, base} + {1'b0, size};
   assign fits       = (base <= acc_addr) && (acc_end <= region_end);
   assign hit_in     = valid && fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== design/hrbt_checker.sv =====
// Port-level checker for the heap region bounds table and its bind to the top level.
module hrbt_checker #(
   parameter int DEPTH = hrbt_pkg::DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_in_bounds,
   input logic                              rsp_dropped,
   input logic [hrbt_pkg::COUNT_OUT_W-1:0]  rsp_used_entries
);

   import hrbt_pkg::*;

   localparam logic [COUNT_OUT_W-1:0] FULL_CODE = COUNT_OUT_W'(DEPTH % (1 << COUNT_OUT_W));
   localparam logic                   WIDE_TABLE = (DEPTH >= (1 << COUNT_OUT_W));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_in_bounds)
         && $stable(rsp_dropped) && $stable(rsp_used_entries))
      else $error("Stalled response changed or vanished.");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_in_bounds && rsp_dropped))
      else $error("Response is both in bounds and dropped.");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_used_entries == FULL_CODE)
      else $error("Record dropped while the table was not full.");

   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_CHECK |=> req_stall || rsp_valid)
      else $error("Check request neither answered nor scanning.");

   a_hit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_bounds |-> WIDE_TABLE || rsp_used_entries != '0)
      else $error("Hit reported on an empty table.");

endmodule

bind heap_region_bounds_table_top hrbt_checker #(
   .DEPTH (DEPTH)
) u_hrbt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_in_bounds    (rsp_in_bounds),
   .rsp_dropped      (rsp_dropped),
   .rsp_used_entries (rsp_used_entries)
);
